// ===== rtl/bvsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bvsd_pkg
// Shared codes and control types of the bounded volume store with difference.
// ----------------------------------------------------------------------------
package bvsd_pkg;

	// operation codes
	localparam logic [1:0] FN_WRITE = 2'd0;
	localparam logic [1:0] FN_READ  = 2'd1;
	localparam logic [1:0] FN_DIFF  = 2'd2;
	localparam logic [1:0] FN_CLEAR = 2'd3;

	// difference axis codes
	localparam logic [1:0] DIR_X   = 2'd0;
	localparam logic [1:0] DIR_Y   = 2'd1;
	localparam logic [1:0] DIR_Z   = 2'd2;
	localparam logic [1:0] DIR_BAD = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_OUT_X   = 3'd1;
	localparam logic [2:0] ST_OUT_Y   = 3'd2;
	localparam logic [2:0] ST_OUT_Z   = 3'd3;
	localparam logic [2:0] ST_BELOW   = 3'd4;
	localparam logic [2:0] ST_ABOVE   = 3'd5;
	localparam logic [2:0] ST_BAD_DIR = 3'd6;

	// configuration register indexes
	localparam logic [1:0] CFG_ENTRY_BITS  = 2'd0;
	localparam logic [1:0] CFG_MAX_INDEX_X = 2'd1;
	localparam logic [1:0] CFG_MAX_INDEX_Y = 2'd2;
	localparam logic [1:0] CFG_MAX_INDEX_Z = 2'd3;

	// reset values of the configuration registers
	localparam logic [5:0] ENTRY_BITS_RST = 6'd32;
	localparam logic [3:0] MAX_INDEX_RST  = 4'd15;

	// commands from controller to datapath
	typedef struct packed {
		logic cap_item;
		logic cap_status;
		logic mem_write;
		logic rd_next;
		logic cap_here;
		logic cap_next;
		logic sweep_we;
		logic load_out;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [1:0] func;
		logic       pass;
		logic       sweep_last;
	} stat_t;

endpackage

// ===== rtl/bvsd_ram.sv =====
// ----------------------------------------------------------------------------
// bvsd_ram
// Generic single-port RAM with one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module bvsd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== rtl/bvsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bvsd_ctrl
// Sequencer of the volume store: handshakes, memory sweep and read steps.
// ----------------------------------------------------------------------------
module bvsd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output bvsd_pkg::cmd_t  cmd,
	input  bvsd_pkg::stat_t stat
);

	import bvsd_pkg::*;

	typedef enum logic [5:0] {
		S_SWEEP = 6'b000001,
		S_IDLE  = 6'b000010,
		S_EXEC  = 6'b000100,
		S_WAIT1 = 6'b001000,
		S_WAIT2 = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   clr_op_q, clr_op_d;
	logic   out_valid_q;
	logic   out_free;
	logic   in_xfer;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		clr_op_d = clr_op_q;
		cmd      = '0;
		unique case (state_q)
			S_SWEEP: begin
				cmd.sweep_we = 1'b1;
				if (stat.sweep_last) begin
					state_d  = clr_op_q ? S_FIN : S_IDLE;
					clr_op_d = 1'b0;
				end
			end
			S_IDLE: begin
				cmd.cap_item = in_xfer;
				if (in_xfer) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.cap_status = 1'b1;
				unique case (stat.func)
					FN_WRITE: begin
						cmd.mem_write = stat.pass;
						state_d       = S_FIN;
					end
					FN_READ, FN_DIFF: begin
						state_d = stat.pass ? S_WAIT1 : S_FIN;
					end
					FN_CLEAR: begin
						clr_op_d = 1'b1;
						state_d  = S_SWEEP;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_WAIT1: begin
				cmd.cap_here = 1'b1;
				if (stat.func == FN_DIFF) begin
					cmd.rd_next = 1'b1;
					state_d     = S_WAIT2;
				end else begin
					state_d = S_FIN;
				end
			end
			S_WAIT2: begin
				cmd.cap_next = 1'b1;
				state_d      = S_FIN;
			end
			S_FIN: begin
				cmd.load_out = out_free;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_SWEEP;
			clr_op_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			clr_op_q <= clr_op_d;
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result overwritten while stalled");

	// an accepted transfer goes straight to execution
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == S_EXEC))
		else $error("accepted item not executed");

	// a store write only for a passed check, never during a sweep
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_write |-> (stat.pass && !cmd.sweep_we))
		else $error("memory written for a failed item");

	// the sweep after reset ends in idle
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && stat.sweep_last && !clr_op_q) |=> (state_q == S_IDLE))
		else $error("reset sweep did not end in idle");

endmodule

// ===== rtl/bvsd_dp.sv =====
// ----------------------------------------------------------------------------
// bvsd_dp
// Datapath: configuration, item registers, checks, store and result register.
// ----------------------------------------------------------------------------
module bvsd_dp #(
	parameter int SIZE_X      = 16,
	parameter int SIZE_Y      = 16,
	parameter int SIZE_Z      = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bvsd_pkg::cmd_t     cmd,
	output bvsd_pkg::stat_t    stat,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [5:0]         cfg_data,
	input  logic [1:0]         func,
	input  logic [3:0]         pos_x,
	input  logic [3:0]         pos_y,
	input  logic [3:0]         pos_z,
	input  logic [1:0]         direction,
	input  logic signed [31:0] write_value,
	output logic [2:0]         status,
	output logic signed [32:0] data_out
);

	import bvsd_pkg::*;

	localparam int DEPTH    = SIZE_X * SIZE_Y * SIZE_Z;
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int STRIDE_Z = SIZE_X * SIZE_Y;
	localparam int DW       = (VALUE_WIDTH + 1 > 33) ? VALUE_WIDTH + 1 : 33;

	// configuration registers
	logic [5:0] entry_bits_q;
	logic [3:0] max_x_q, max_y_q, max_z_q;

	// item registers
	logic [1:0]         func_q, dir_q;
	logic [3:0]         x_q, y_q, z_q;
	logic signed [31:0] wval_q;

	// results of the memory reads
	logic [VALUE_WIDTH-1:0] here_q, next_q, rdata;
	logic [2:0]             status_q, status_c;
	logic [AW-1:0]          sweep_q, addr_here, addr_next, stride, mem_addr;
	logic [VALUE_WIDTH-1:0] mem_wdata;
	logic                   mem_we;

	logic [5:0]         b_eff, b_cap;
	logic [3:0]         lx, ly, lz;
	logic               fail_x, fail_y, fail_z;
	logic signed [33:0] wv34, mx, mn;
	logic signed [63:0] wv64;
	logic signed [DW-1:0] ext_here, ext_next, diff;

	// sign-extend the low bits of a stored word; zero bits give zero
	function automatic logic signed [DW-1:0] sext(input logic [VALUE_WIDTH-1:0] word,
		input logic [5:0] bits);
		logic [5:0]                    sh;
		logic signed [VALUE_WIDTH-1:0] t;
		sh = 6'(VALUE_WIDTH) - bits;
		t  = VALUE_WIDTH'(word << sh);
		t  = t >>> sh;
		return (bits == 6'd0) ? '0 : DW'(t);
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_bits_q <= ENTRY_BITS_RST;
			max_x_q      <= MAX_INDEX_RST;
			max_y_q      <= MAX_INDEX_RST;
			max_z_q      <= MAX_INDEX_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_ENTRY_BITS:  entry_bits_q <= cfg_data;
				CFG_MAX_INDEX_X: max_x_q      <= cfg_data[3:0];
				CFG_MAX_INDEX_Y: max_y_q      <= cfg_data[3:0];
				CFG_MAX_INDEX_Z: max_z_q      <= cfg_data[3:0];
				default:         entry_bits_q <= entry_bits_q;
			endcase
		end
	end

	// capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.cap_item) begin
			func_q <= func;
			x_q    <= pos_x;
			y_q    <= pos_y;
			z_q    <= pos_z;
			dir_q  <= direction;
			wval_q <= write_value;
		end
	end

	// effective limits
	assign b_eff = (entry_bits_q > 6'(VALUE_WIDTH)) ? 6'(VALUE_WIDTH) : entry_bits_q;
	assign lx = (32'(max_x_q) > 32'(SIZE_X - 1)) ? 4'(SIZE_X - 1) : max_x_q;
	assign ly = (32'(max_y_q) > 32'(SIZE_Y - 1)) ? 4'(SIZE_Y - 1) : max_y_q;
	assign lz = (32'(max_z_q) > 32'(SIZE_Z - 1)) ? 4'(SIZE_Z - 1) : max_z_q;

	// position checks, the difference axis loses its last index
	assign fail_x = (x_q > lx) || (func_q == FN_DIFF && dir_q == DIR_X && x_q >= lx);
	assign fail_y = (y_q > ly) || (func_q == FN_DIFF && dir_q == DIR_Y && y_q >= ly);
	assign fail_z = (z_q > lz) || (func_q == FN_DIFF && dir_q == DIR_Z && z_q >= lz);

	// value range of a write; widths past 33 bits admit every input
	assign b_cap = (b_eff > 6'd33) ? 6'd33 : b_eff;
	assign wv34  = 34'(wval_q);
	assign mx    = (b_cap == 6'd0) ? 34'sd0 : (34'sd1 <<< (b_cap - 6'd1)) - 34'sd1;
	assign mn    = (b_cap == 6'd0) ? 34'sd0 : -mx - 34'sd1;
	assign wv64  = 64'(wval_q);

	// first error found
	always_comb begin
		priority if (func_q == FN_CLEAR) begin
			status_c = ST_OK;
		end else if (func_q == FN_DIFF && dir_q == DIR_BAD) begin
			status_c = ST_BAD_DIR;
		end else if (fail_x) begin
			status_c = ST_OUT_X;
		end else if (fail_y) begin
			status_c = ST_OUT_Y;
		end else if (fail_z) begin
			status_c = ST_OUT_Z;
		end else if (func_q == FN_WRITE && wv34 < mn) begin
			status_c = ST_BELOW;
		end else if (func_q == FN_WRITE && wv34 > mx) begin
			status_c = ST_ABOVE;
		end else begin
			status_c = ST_OK;
		end
	end

	// addresses: x fastest, then y, then z
	assign addr_here = AW'(x_q) + AW'(y_q) * AW'(SIZE_X) + AW'(z_q) * AW'(STRIDE_Z);
	always_comb begin
		unique case (dir_q)
			DIR_Y:   stride = AW'(SIZE_X);
			DIR_Z:   stride = AW'(STRIDE_Z);
			default: stride = AW'(1);
		endcase
	end
	assign addr_next = addr_here + stride;

	// memory port select
	always_comb begin
		priority if (cmd.sweep_we) begin
			mem_addr = sweep_q;
		end else if (cmd.rd_next) begin
			mem_addr = addr_next;
		end else begin
			mem_addr = addr_here;
		end
	end
	assign mem_we    = cmd.sweep_we || cmd.mem_write;
	assign mem_wdata = cmd.sweep_we ? '0 : wv64[VALUE_WIDTH-1:0];

	bvsd_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (rdata)
	);

	// sweep address counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_we) begin
			sweep_q <= stat.sweep_last ? '0 : sweep_q + AW'(1);
		end
	end

	// status and read data
	always_ff @(posedge clk) begin
		if (cmd.cap_status) begin
			status_q <= status_c;
		end
		if (cmd.cap_here) begin
			here_q <= rdata;
		end
		if (cmd.cap_next) begin
			next_q <= rdata;
		end
	end

	// result formation
	assign ext_here = sext(here_q, b_eff);
	assign ext_next = sext(next_q, b_eff);
	assign diff     = ext_next - ext_here;

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status <= status_q;
			if (status_q != ST_OK) begin
				data_out <= '0;
			end else begin
				unique case (func_q)
					FN_READ: data_out <= ext_here[32:0];
					FN_DIFF: data_out <= diff[32:0];
					default: data_out <= '0;
				endcase
			end
		end
	end

	assign stat.func       = func_q;
	assign stat.pass       = (status_c == ST_OK);
	assign stat.sweep_last = (sweep_q == AW'(DEPTH - 1));

endmodule

// ===== rtl/bounded_volume_store_with_difference.sv =====
// ----------------------------------------------------------------------------
// bounded_volume_store_with_difference
// Volume of signed entries with checked write, read, forward difference and
// clear, held in one single-port RAM.
//
// channel   direction  handshake               payload
// input     in         in_valid / in_stall     func pos_x pos_y pos_z direction
//                                              write_value
// output    out        out_valid / out_stall   status data_out
// config    in         cfg_write               cfg_index cfg_data
//
// states per item, accept to result: write EXEC FIN, read EXEC WAIT1 FIN, difference
// EXEC WAIT1 WAIT2 FIN, bad position or bad direction EXEC FIN, clear EXEC SWEEP FIN
// (the sweep zeroes one entry per cycle); the single RAM port allows one read or write
// per cycle, with registered read data; after reset all SIZE_X*SIZE_Y*SIZE_Z entries
// (4096 by default) of the RAM are zeroed, in_stall high meanwhile
// one item is in work at a time; the next transfer is taken while a result
// waits on a stalled output
// ----------------------------------------------------------------------------
module bounded_volume_store_with_difference #(
	parameter int SIZE_X      = 16,
	parameter int SIZE_Y      = 16,
	parameter int SIZE_Z      = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [5:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [3:0]         pos_x,
	input  logic [3:0]         pos_y,
	input  logic [3:0]         pos_z,
	input  logic [1:0]         direction,
	input  logic signed [31:0] write_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [32:0] data_out
);

	import bvsd_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	bvsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// store and arithmetic
	bvsd_dp #(
		.SIZE_X      (SIZE_X),
		.SIZE_Y      (SIZE_Y),
		.SIZE_Z      (SIZE_Z),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.func        (func),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.direction   (direction),
		.write_value (write_value),
		.status      (status),
		.data_out    (data_out)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded volume store with difference. A planned
// list of operations and register writes feeds the input driver; an in-bench
// copy of the volume and its registers predicts status and data for each
// accepted transfer, and the output monitor checks them in order.
// ----------------------------------------------------------------------------
module tb_top;
	import bvsd_pkg::*;

	localparam int STALL_LIMIT  = 30000;   // cycles with no transfer and no register write
	localparam int SETTLE_WAIT  = 3;       // idle cycles around register writes
	localparam int TAIL_CYCLES  = 20;
	localparam int CALM_FIRST   = 300;     // window with no gaps on either side
	localparam int CALM_LAST    = 550;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 105;

	typedef enum logic [1:0] {
		STEP_ITEM,
		STEP_DRAIN,
		STEP_REG
	} step_kind_t;

	typedef struct {
		step_kind_t         kind;
		logic [1:0]         op;
		logic [3:0]         x;
		logic [3:0]         y;
		logic [3:0]         z;
		logic [1:0]         axis;
		logic signed [31:0] value;
		logic [1:0]         reg_idx;
		logic [5:0]         reg_val;
	} stim_step_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_write   = 1'b0;
	logic [1:0]         cfg_index   = '0;
	logic [5:0]         cfg_data    = '0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic [1:0]         func        = '0;
	logic [3:0]         pos_x       = '0;
	logic [3:0]         pos_y       = '0;
	logic [3:0]         pos_z       = '0;
	logic [1:0]         direction   = '0;
	logic signed [31:0] write_value = '0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic [2:0]         status;
	logic signed [32:0] data_out;

	// planned stimulus and results still owed by the block
	stim_step_t         stim_plan [$];
	logic [2:0]         status_due [4096];
	logic signed [32:0] data_due [4096];
	int                 n_sent       = 0;
	int                 n_recv       = 0;
	int                 fails        = 0;
	int                 settle_cnt   = 0;
	int                 quiet_cycles = 0;

	// predicted contents of the volume and its registers
	logic [31:0]        vol [4096];
	logic [5:0]         cur_bits = ENTRY_BITS_RST;
	logic [3:0]         lim_x    = MAX_INDEX_RST;
	logic [3:0]         lim_y    = MAX_INDEX_RST;
	logic [3:0]         lim_z    = MAX_INDEX_RST;

	// register setting the stimulus is currently planned against
	logic [5:0]         gen_bits = ENTRY_BITS_RST;
	logic [3:0]         gen_mx   = MAX_INDEX_RST;
	logic [3:0]         gen_my   = MAX_INDEX_RST;
	logic [3:0]         gen_mz   = MAX_INDEX_RST;

	bounded_volume_store_with_difference i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.direction   (direction),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.data_out    (data_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// first failing axis, with the limit of one axis pulled in by one for a difference
	function automatic logic [2:0] position_fault(logic [3:0] x, logic [3:0] y,
			logic [3:0] z, logic [1:0] shrink);
		if (x > lim_x || (shrink == DIR_X && x >= lim_x)) return ST_OUT_X;
		if (y > lim_y || (shrink == DIR_Y && y >= lim_y)) return ST_OUT_Y;
		if (z > lim_z || (shrink == DIR_Z && z >= lim_z)) return ST_OUT_Z;
		return ST_OK;
	endfunction

	// stored word seen through the current entry width, sign-extended
	function automatic longint entry_value(logic [11:0] addr);
		int     b;
		longint t;
		b = (cur_bits > 6'd32) ? 32 : int'(cur_bits);
		if (b == 0) return 0;
		t = longint'({32'd0, vol[addr]}) << (64 - b);
		return t >>> (64 - b);
	endfunction

	// status and data for the operation on the input lines, updating the volume
	task automatic volume_response(output logic [2:0] st, output logic signed [32:0] dat);
		int          b;
		longint      wv;
		longint      hi;
		longint      lo;
		longint      diff;
		logic [3:0]  nx;
		logic [3:0]  ny;
		logic [3:0]  nz;
		st  = ST_OK;
		dat = '0;
		b   = (cur_bits > 6'd32) ? 32 : int'(cur_bits);
		case (func)
			FN_WRITE: begin
				wv = longint'(write_value);
				hi = (b == 0) ? 0 : (longint'(1) << (b - 1)) - 1;
				lo = (b == 0) ? 0 : -hi - 1;
				st = position_fault(pos_x, pos_y, pos_z, DIR_BAD);
				if (st == ST_OK) begin
					if (wv < lo)
						st = ST_BELOW;
					else if (wv > hi)
						st = ST_ABOVE;
					else
						vol[{pos_z, pos_y, pos_x}] = write_value;
				end
			end
			FN_READ: begin
				st = position_fault(pos_x, pos_y, pos_z, DIR_BAD);
				if (st == ST_OK) begin
					diff = entry_value({pos_z, pos_y, pos_x});
					dat  = diff[32:0];
				end
			end
			FN_DIFF: begin
				if (direction == DIR_BAD) begin
					st = ST_BAD_DIR;
				end else begin
					st = position_fault(pos_x, pos_y, pos_z, direction);
					if (st == ST_OK) begin
						nx   = pos_x + 4'(direction == DIR_X);
						ny   = pos_y + 4'(direction == DIR_Y);
						nz   = pos_z + 4'(direction == DIR_Z);
						diff = entry_value({nz, ny, nx}) - entry_value({pos_z, pos_y, pos_x});
						dat  = diff[32:0];
					end
				end
			end
			default: begin
				foreach (vol[i])
					vol[i] = '0;
			end
		endcase
	endtask

	// input driver: operations, drains before and after register writes, writes
	always @(posedge clk) begin : p_drive
		logic       took;
		logic       nxt_valid;
		logic       nxt_cfg;
		logic       gap;
		int         settle_nxt;
		logic [2:0] exp_st;
		logic [32:0] exp_data;
		stim_step_t head;
		if (arst_n) begin
			took       = in_valid && !in_stall;
			nxt_valid  = in_valid && !took;
			nxt_cfg    = 1'b0;
			settle_nxt = settle_cnt;
			if (took) begin
				volume_response(exp_st, exp_data);
				status_due[n_sent % 4096] <= exp_st;
				data_due[n_sent % 4096]   <= exp_data;
				n_sent <= n_sent + 1;
			end
			if (!nxt_valid && stim_plan.size() != 0) begin
				head = stim_plan[0];
				case (head.kind)
					STEP_ITEM: begin
						gap = !(n_sent >= CALM_FIRST && n_sent < CALM_LAST) &&
							$urandom_range(99) < 13;
						if (!gap) begin
							void'(stim_plan.pop_front());
							func        <= head.op;
							pos_x       <= head.x;
							pos_y       <= head.y;
							pos_z       <= head.z;
							direction   <= head.axis;
							write_value <= head.value;
							nxt_valid   = 1'b1;
						end
					end
					STEP_DRAIN: begin
						// hold off until every owed result is back and the settle counter reaches SETTLE_WAIT
						if (!took && n_sent == n_recv) begin
							if (settle_cnt >= SETTLE_WAIT) begin
								void'(stim_plan.pop_front());
								settle_nxt = 0;
							end else begin
								settle_nxt = settle_cnt + 1;
							end
						end else begin
							settle_nxt = 0;
						end
					end
					default: begin
						void'(stim_plan.pop_front());
						nxt_cfg = 1'b1;
						cfg_index <= head.reg_idx;
						cfg_data  <= head.reg_val;
						case (head.reg_idx)
							CFG_ENTRY_BITS:  cur_bits = head.reg_val;
							CFG_MAX_INDEX_X: lim_x    = head.reg_val[3:0];
							CFG_MAX_INDEX_Y: lim_y    = head.reg_val[3:0];
							default:         lim_z    = head.reg_val[3:0];
						endcase
					end
				endcase
			end
			in_valid   <= nxt_valid;
			cfg_write  <= nxt_cfg;
			settle_cnt <= settle_nxt;
		end
	end

	// output monitor: compare each transfer with the oldest owed result
	always @(posedge clk) begin : p_check
		int idx;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (n_recv == n_sent) begin
					$error("output transfer with no result owed: status %0d data_out %0d",
						status, data_out);
					fails++;
				end else begin
					idx = n_recv % 4096;
					if (status !== status_due[idx]) begin
						$error("status: expected %0d, actual %0d", status_due[idx], status);
						fails++;
					end
					if (data_out !== data_due[idx]) begin
						$error("data_out: expected %0d, actual %0d", data_due[idx], data_out);
						fails++;
					end
					n_recv <= n_recv + 1;
				end
			end
			out_stall <= !(n_recv >= CALM_FIRST && n_recv < CALM_LAST) &&
				$urandom_range(99) < 13;
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin : p_watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_op(logic [1:0] op, logic [3:0] x, logic [3:0] y, logic [3:0] z,
			logic [1:0] axis, logic signed [31:0] value);
		stim_step_t s;
		s.kind    = STEP_ITEM;
		s.op      = op;
		s.x       = x;
		s.y       = y;
		s.z       = z;
		s.axis    = axis;
		s.value   = value;
		s.reg_idx = CFG_ENTRY_BITS;
		s.reg_val = '0;
		stim_plan.push_back(s);
	endtask

	// all four registers, written only with the block idle
	task automatic queue_config(logic [5:0] bits, logic [3:0] mx, logic [3:0] my,
			logic [3:0] mz);
		stim_step_t s;
		s = '{STEP_DRAIN, FN_READ, 4'd0, 4'd0, 4'd0, DIR_X, 32'sd0, CFG_ENTRY_BITS, 6'd0};
		stim_plan.push_back(s);
		s.kind = STEP_REG;
		s.reg_idx = CFG_ENTRY_BITS;  s.reg_val = bits;        stim_plan.push_back(s);
		s.reg_idx = CFG_MAX_INDEX_X; s.reg_val = {2'b00, mx}; stim_plan.push_back(s);
		s.reg_idx = CFG_MAX_INDEX_Y; s.reg_val = {2'b00, my}; stim_plan.push_back(s);
		s.reg_idx = CFG_MAX_INDEX_Z; s.reg_val = {2'b00, mz}; stim_plan.push_back(s);
		s.kind = STEP_DRAIN;
		stim_plan.push_back(s);
		gen_bits = bits;
		gen_mx   = mx;
		gen_my   = my;
		gen_mz   = mz;
	endtask

	// mostly in-range positions and values, some boundary values and raw noise
	task automatic queue_random_op();
		int          r;
		int          b;
		longint      hi;
		longint      wv;
		logic [1:0]  op;
		logic [3:0]  x;
		logic [3:0]  y;
		logic [3:0]  z;
		logic [1:0]  axis;
		logic [31:0] raw;
		r  = $urandom_range(999);
		op = (r < 15) ? FN_CLEAR : (r < 380) ? FN_WRITE : (r < 680) ? FN_READ : FN_DIFF;
		if ($urandom_range(99) < 85) begin
			x = 4'($urandom_range(int'(gen_mx)));
			y = 4'($urandom_range(int'(gen_my)));
			z = 4'($urandom_range(int'(gen_mz)));
		end else begin
			x = 4'($urandom);
			y = 4'($urandom);
			z = 4'($urandom);
		end
		axis = ($urandom_range(99) < 10) ? DIR_BAD : 2'($urandom_range(2));
		b    = (gen_bits > 6'd32) ? 32 : int'(gen_bits);
		hi   = (b == 0) ? 0 : (longint'(1) << (b - 1)) - 1;
		raw  = $urandom;
		r    = $urandom_range(99);
		if (r < 60) begin
			if (b == 0)
				raw = '0;
			else begin
				wv  = (longint'({32'd0, raw}) << (64 - b)) >>> (64 - b);
				raw = wv[31:0];
			end
		end else if (r < 75) begin
			case ($urandom_range(3))
				0:       wv = hi;
				1:       wv = -hi - 1;
				2:       wv = hi + 1;
				default: wv = -hi - 2;
			endcase
			raw = wv[31:0];
		end
		queue_op(op, x, y, z, axis, raw);
	endtask

	initial begin : p_plan
		logic [5:0] tbl_bits [6];
		logic [3:0] tbl_mx [6];
		logic [3:0] tbl_my [6];
		logic [3:0] tbl_mz [6];
		tbl_bits = '{6'd32, 6'd8, 6'd1, 6'd16, 6'd63, 6'd0};
		tbl_mx   = '{4'd15, 4'd3, 4'd1, 4'd0, 4'd15, 4'd2};
		tbl_my   = '{4'd15, 4'd3, 4'd2, 4'd15, 4'd0, 4'd2};
		tbl_mz   = '{4'd15, 4'd3, 4'd0, 4'd7, 4'd15, 4'd2};
		foreach (vol[i])
			vol[i] = '0;

		// full-width extremes and the widest possible differences
		queue_op(FN_WRITE, 4'd0, 4'd0, 4'd0, DIR_Z, 32'h8000_0000);
		queue_op(FN_WRITE, 4'd1, 4'd0, 4'd0, DIR_BAD, 32'h7FFF_FFFF);
		queue_op(FN_WRITE, 4'd2, 4'd0, 4'd0, DIR_Y, 32'h8000_0000);
		queue_op(FN_DIFF, 4'd0, 4'd0, 4'd0, DIR_X, 32'h5A5A_A5A5);
		queue_op(FN_DIFF, 4'd1, 4'd0, 4'd0, DIR_X, 32'hFFFF_FFFF);
		queue_op(FN_READ, 4'd1, 4'd0, 4'd0, DIR_BAD, 32'hFFFF_FFFF);
		queue_op(FN_READ, 4'd15, 4'd15, 4'd15, DIR_X, 32'd0);
		// difference from the last index of each axis, and a bad axis code
		queue_op(FN_DIFF, 4'd15, 4'd0, 4'd0, DIR_X, 32'd0);
		queue_op(FN_DIFF, 4'd0, 4'd15, 4'd0, DIR_Y, 32'd0);
		queue_op(FN_DIFF, 4'd0, 4'd0, 4'd15, DIR_Z, 32'd0);
		queue_op(FN_DIFF, 4'd15, 4'd15, 4'd15, DIR_BAD, 32'd0);
		queue_op(FN_CLEAR, 4'd9, 4'd3, 4'd12, DIR_BAD, 32'h1234_5678);
		queue_op(FN_READ, 4'd0, 4'd0, 4'd0, DIR_X, 32'd0);

		// narrow entries and small limits: position order, then min and max
		queue_config(6'd8, 4'd3, 4'd0, 4'd15);
		queue_op(FN_WRITE, 4'd4, 4'd0, 4'd0, DIR_X, 32'sd0);
		queue_op(FN_WRITE, 4'd0, 4'd1, 4'd0, DIR_X, -32'sd129);
		queue_op(FN_WRITE, 4'd3, 4'd0, 4'd15, DIR_X, -32'sd129);
		queue_op(FN_WRITE, 4'd3, 4'd0, 4'd15, DIR_X, 32'sd128);
		queue_op(FN_WRITE, 4'd3, 4'd0, 4'd15, DIR_X, 32'sd127);
		queue_op(FN_DIFF, 4'd0, 4'd0, 4'd0, DIR_Y, 32'd0);
		queue_op(FN_DIFF, 4'd3, 4'd0, 4'd14, DIR_Z, 32'd0);
		// width shrunk after the write: low bits read back sign-extended
		queue_config(6'd4, 4'd15, 4'd15, 4'd15);
		queue_op(FN_READ, 4'd3, 4'd0, 4'd15, DIR_X, 32'd0);
		// zero width: only a zero write passes, reads give zero
		queue_config(6'd0, 4'd15, 4'd15, 4'd15);
		queue_op(FN_WRITE, 4'd5, 4'd5, 4'd5, DIR_X, 32'sd0);
		queue_op(FN_WRITE, 4'd5, 4'd5, 4'd5, DIR_X, 32'sd1);
		queue_op(FN_WRITE, 4'd5, 4'd5, 4'd5, DIR_X, -32'sd1);
		queue_op(FN_READ, 4'd3, 4'd0, 4'd15, DIR_X, 32'd0);

		// random phases over fixed and random register settings
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 6)
				queue_config(tbl_bits[ph], tbl_mx[ph], tbl_my[ph], tbl_mz[ph]);
			else
				queue_config(6'($urandom_range(63)), 4'($urandom), 4'($urandom),
					4'($urandom));
			for (int i = 0; i < PHASE_ITEMS; i++)
				queue_random_op();
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (stim_plan.size() != 0 || in_valid || n_recv != n_sent)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fails == 0 && n_recv == n_sent) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== bounded_volume_store_with_difference.f =====
rtl/bvsd_pkg.sv
rtl/bvsd_ram.sv
rtl/bvsd_ctrl.sv
rtl/bvsd_dp.sv
rtl/bounded_volume_store_with_difference.sv
tb/sv/tb_top.sv
